/* rtl/core/fpagc_pkg.sv */
// ----------------------------------------------------------------------------
// fpagc_pkg
// Shared constants, types and helpers of the frame peak gain control block.
// ----------------------------------------------------------------------------
package fpagc_pkg;

    localparam int FRAME_MAX  = 256;
    localparam int POS_W      = $clog2(FRAME_MAX);
    localparam int CFG_LEN_W  = 9;
    localparam int LEN_X_W    = (POS_W + 1 > CFG_LEN_W) ? POS_W + 1 : CFG_LEN_W;
    localparam int HIST_DEPTH = 25;
    localparam int HIST_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HCNT_W     = $clog2(HIST_DEPTH + 1);

    localparam int SMP_W      = 16;
    localparam int VOL_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int STEP_W     = 32;
    localparam int RPROD_W    = POS_W + STEP_W;
    localparam int NSTEP_W    = LEN_X_W + STEP_W;
    localparam int MV_W       = SMP_W + VOL_W;
    localparam int PP_W       = MV_W + 16;

    localparam int DIV_N_W    = 33;
    localparam int DIV_D_W    = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

    // The step limit gain/20 is taken as (gain/4)/5, the division by five as a
    // multiplication by a 32-bit reciprocal that is exact for any 32-bit value.
    localparam int LIM_RECIP_W = 32;
    localparam int LIM_PROD_W  = GAIN_W - 2 + LIM_RECIP_W;
    localparam int LIM_SHIFT   = 34;
    localparam logic [LIM_RECIP_W-1:0] LIM_RECIP = 32'hCCCCCCCD;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGC_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME       = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 24'd6553600;
    localparam logic [GAIN_W-1:0]  GAIN_CAP   = 24'd13107200;
    localparam logic [GAIN_W-1:0]  GAIN_MAX   = 24'hFFFFFF;
    localparam logic [STEP_W-1:0]  RAMP_MAX   = 32'hFFFFFFFF;
    localparam logic [SMP_W-1:0]   OUT_CLAMP  = 16'd32760;
    localparam logic [DIV_N_W-1:0] TARGET_NUM = 33'd7864320000;
    localparam logic [CFG_LEN_W-1:0] LEN_RESET  = 9'd160;
    localparam logic [VOL_W-1:0]     VOL_RESET  = 16'd32768;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_OUT, S_EOF
    } t_state;

    typedef enum logic [2:0] {
        G_IDLE, G_ADD, G_SCAN, G_TDIV, G_DECIDE, G_LDIV, G_SDIV
    } t_gstate;

    typedef struct packed {
        logic               start;
        logic               agc;
        logic [LEN_X_W-1:0] n;
        logic [SMP_W-1:0]   peak;
    } t_gain_ctl;

    typedef struct packed {
        logic              busy;
        logic [GAIN_W-1:0] gain;
        logic [STEP_W-1:0] step;
    } t_gain_stat;

    function automatic logic [SMP_W-1:0] abs16(input logic [SMP_W-1:0] v);
        abs16 = v[SMP_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

/* rtl/core/fpagc_div.sv */
// ----------------------------------------------------------------------------
// fpagc_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpagc_div
    import fpagc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dvs;
    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W:0]     w_shift;
    logic                 w_ge;

    assign w_shift = {r_rem, r_q[DIV_N_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= w_ge ? DIV_D_W'(w_shift - {1'b0, r_dvs}) : w_shift[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], w_ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/core/fpagc_gain.sv */
// ----------------------------------------------------------------------------
// fpagc_gain
// Frame end gain update: ramp completion, peak ring scan and gain decision.
// ----------------------------------------------------------------------------
module fpagc_gain
    import fpagc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_gain_ctl  i_ctl,
    output t_gain_stat o_stat
);

    t_gstate r_state, n_state;

    logic [GAIN_W-1:0]  r_gain;
    logic [STEP_W-1:0]  r_step;
    logic [HIST_W-1:0]  r_hp;
    logic [LEN_X_W-1:0] r_n;
    logic [SMP_W-1:0]   r_peak;
    logic               r_agc;
    logic [NSTEP_W-1:0] r_nstep;
    logic [HCNT_W-1:0]  r_idx;
    logic               r_rvalid;
    logic [SMP_W-1:0]   r_max;
    logic [DIV_N_W-1:0] r_target;
    logic [GAIN_W-1:0]  r_lim;

    logic [SMP_W-1:0]   r_hist [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_hvalid;
    logic [SMP_W-1:0]   r_hrd;
    logic               r_hrd_ok;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quot;

    logic [SMP_W-1:0]   w_hval;
    logic [SMP_W-1:0]   w_max;
    logic               w_scan_end;
    logic               w_issue;
    logic               w_lower;
    logic [GAIN_W-1:0]  w_delta;
    logic [GAIN_W-1:0]  w_dmin;
    logic [NSTEP_W-8:0] w_gsum;
    logic [LIM_PROD_W-1:0] w_lim_prod;
    logic [GAIN_W-1:0]  w_lim;

    assign w_hval     = r_hrd_ok ? r_hrd : '0;
    assign w_max      = (r_rvalid && (w_hval > r_max)) ? w_hval : r_max;
    assign w_scan_end = (r_idx == HCNT_W'(HIST_DEPTH)) && r_rvalid;
    assign w_issue    = (r_state == G_SCAN) && (r_idx < HCNT_W'(HIST_DEPTH));
    assign w_lower    = r_target < DIV_N_W'(r_gain);
    assign w_delta    = (r_target[GAIN_W-1:0] > r_gain) ? r_target[GAIN_W-1:0] - r_gain : '0;
    assign w_dmin     = (w_delta > r_lim) ? r_lim : w_delta;
    assign w_gsum     = (NSTEP_W-7)'(r_gain) + (NSTEP_W-7)'(r_nstep[NSTEP_W-1:8]);
    assign w_lim_prod = LIM_PROD_W'(r_gain[GAIN_W-1:2]) * LIM_PROD_W'(LIM_RECIP);
    assign w_lim      = GAIN_W'(w_lim_prod[LIM_PROD_W-1:LIM_SHIFT]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE:   if (i_ctl.start) n_state = G_ADD;
            G_ADD:    n_state = r_agc ? G_SCAN : G_IDLE;
            G_SCAN: begin
                if (w_scan_end) n_state = (w_max == '0) ? G_DECIDE : G_TDIV;
            end
            G_TDIV:   if (div_done) n_state = G_DECIDE;
            G_DECIDE: n_state = w_lower ? G_IDLE : G_LDIV;
            G_LDIV:   n_state = G_SDIV;
            G_SDIV:   if (div_done) n_state = G_IDLE;
            default:  n_state = G_IDLE;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = TARGET_NUM;
        div_divisor  = DIV_D_W'(w_max);
        unique case (r_state)
            G_SCAN: begin
                div_start = w_scan_end && (w_max != '0);
            end
            G_LDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'({w_dmin, 8'd0});
                div_divisor  = DIV_D_W'(r_n);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= G_IDLE;
            r_gain   <= GAIN_RESET;
            r_step   <= '0;
            r_hp     <= '0;
            r_hvalid <= '0;
            r_rvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= w_issue;
            unique case (r_state)
                G_IDLE: begin
                    if (i_ctl.start) begin
                        r_nstep <= NSTEP_W'(i_ctl.n * r_step);
                        r_n     <= i_ctl.n;
                        r_peak  <= i_ctl.peak;
                        r_agc   <= i_ctl.agc;
                    end
                end
                G_ADD: begin
                    r_gain <= (w_gsum > (NSTEP_W-7)'(GAIN_MAX)) ? GAIN_MAX
                                                                : w_gsum[GAIN_W-1:0];
                    r_step <= '0;
                    r_idx  <= '0;
                    r_max  <= '0;
                    if (r_agc) begin
                        r_hvalid[r_hp] <= 1'b1;
                        r_hp <= (r_hp == HIST_W'(HIST_DEPTH - 1)) ? '0 : r_hp + 1'b1;
                    end
                end
                G_SCAN: begin
                    r_max <= w_max;
                    if (w_issue) r_idx <= r_idx + 1'b1;
                    if (w_scan_end && (w_max == '0)) r_target <= DIV_N_W'(GAIN_CAP);
                end
                G_TDIV: begin
                    if (div_done) r_target <= div_quot;
                end
                G_DECIDE: begin
                    if (w_lower) begin
                        r_gain <= r_target[GAIN_W-1:0];
                    end else begin
                        r_lim <= w_lim;
                        if (r_target > DIV_N_W'(GAIN_CAP)) r_target <= DIV_N_W'(GAIN_CAP);
                    end
                end
                G_LDIV: begin
                end
                G_SDIV: begin
                    if (div_done) r_step <= div_quot[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == G_ADD) && r_agc) r_hist[r_hp] <= r_peak;
        if (w_issue) begin
            r_hrd    <= r_hist[r_idx[HIST_W-1:0]];
            r_hrd_ok <= r_hvalid[r_idx[HIST_W-1:0]];
        end
    end

    fpagc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_stat.busy = (r_state != G_IDLE);
    assign o_stat.gain = r_gain;
    assign o_stat.step = r_step;

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == G_TDIV || r_state == G_LDIV || r_state == G_SDIV))
        else $error("divider finished outside a wait state");

    a_hp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hp <= HIST_W'(HIST_DEPTH - 1))
        else $error("history pointer out of range");

endmodule

/* rtl/core/frame_peak_agc.sv */
// ----------------------------------------------------------------------------
// frame_peak_agc
// Peak hold automatic gain control over frames of 16-bit audio samples.
// ----------------------------------------------------------------------------
// Samples enter on the i_smp_valid / o_smp_stall channel, one beat each, and
// every input beat yields exactly one result beat on o_res_valid / i_res_stall.
// A result carries the sample stored at the same frame position one frame
// earlier, scaled by the ramped gain and the volume with gain control on and
// unscaled with it off; o_out_valid is low on every result of the first frame
// after reset. Configuration is written through i_cfg_wr_en, i_cfg_addr and
// i_cfg_wdata; the user must write it only while no beat is in flight, and
// the block itself has no check for this. A sample passes S_MUL1, S_MUL2 and
// S_MUL3 before S_OUT loads the output register, and new samples stall until
// it is loaded. The last sample of a frame adds the gain update; with gain
// control on this also runs the ring scan and up to two passes of the shared
// one-bit-per-cycle divider. The output register holds one result, so a
// stalled receiver lets the next beat be accepted and worked on; the block
// then waits with stall high until the register frees. Reset clears the gain
// to 25.0, the peak ring, the frame position and the output register.
// ----------------------------------------------------------------------------
module frame_peak_agc
    import fpagc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [VOL_W-1:0]        i_cfg_wdata,
    input  logic                    i_smp_valid,
    output logic                    o_smp_stall,
    input  logic signed [SMP_W-1:0] i_sample_in,
    output logic                    o_res_valid,
    input  logic                    i_res_stall,
    output logic signed [SMP_W-1:0] o_sample_out,
    output logic                    o_out_valid,
    output logic                    o_out_last,
    output logic [SMP_W-1:0]        o_level
);

    t_state r_state, n_state;

    logic                 r_agc;
    logic [CFG_LEN_W-1:0] r_flen;
    logic [VOL_W-1:0]     r_vol;

    logic [SMP_W-1:0]     r_store [FRAME_MAX];
    logic [SMP_W-1:0]     r_rd;

    logic [POS_W-1:0]     r_sp;
    logic [POS_W-1:0]     r_pos;
    logic                 r_fin;
    logic [SMP_W-1:0]     r_x;
    logic [SMP_W-1:0]     r_peak;
    logic                 r_have;
    logic [SMP_W-1:0]     r_level;

    logic [MV_W-1:0]      r_mv;
    logic                 r_neg;
    logic [SMP_W-1:0]     r_raw;
    logic [RPROD_W-1:0]   r_rprod;
    logic [STEP_W-1:0]    r_g;
    logic [PP_W-1:0]      r_phi;
    logic [PP_W-1:0]      r_plo;

    logic                 r_res_valid;
    logic [SMP_W-1:0]     r_sample_out;
    logic                 r_out_valid;
    logic                 r_out_last;
    logic [SMP_W-1:0]     r_level_out;

    t_gain_ctl            w_gctl;
    t_gain_stat           w_gstat;

    logic                 w_acc;
    logic                 w_free;
    logic                 w_load;
    logic [LEN_X_W-1:0]   w_len;
    logic                 w_fin;
    logic [SMP_W-1:0]     w_mag_in;
    logic [SMP_W-1:0]     w_ax;
    logic [RPROD_W:0]     w_gsum;
    logic [PP_W+15:0]     w_prod;
    logic [SMP_W-1:0]     w_mag_out;
    logic [SMP_W-1:0]     w_y;
    logic [SMP_W-1:0]     w_ay;
    logic [SMP_W-1:0]     w_base;
    logic [SMP_W-1:0]     w_lvl;

    always_comb begin
        if (r_flen == '0) begin
            w_len = LEN_X_W'(1);
        end else if (LEN_X_W'(r_flen) > LEN_X_W'(FRAME_MAX)) begin
            w_len = LEN_X_W'(FRAME_MAX);
        end else begin
            w_len = LEN_X_W'(r_flen);
        end
    end

    assign w_fin     = (LEN_X_W'(r_sp) + 1'b1) >= w_len;
    assign w_mag_in  = abs16(r_rd);
    assign w_ax      = abs16(r_x);
    assign w_gsum    = (RPROD_W+1)'({w_gstat.gain, 8'd0}) + (RPROD_W+1)'(r_rprod);
    assign w_prod    = {r_phi, 16'd0} + (PP_W+16)'(r_plo);
    assign w_mag_out = (w_prod[PP_W+15:41] > (PP_W-25)'(OUT_CLAMP)) ? OUT_CLAMP
                                                                    : w_prod[56:41];
    assign w_y       = !r_agc ? r_raw : (r_neg ? (~w_mag_out + 1'b1) : w_mag_out);
    assign w_ay      = abs16(w_y);
    assign w_base    = (r_pos == '0) ? '0 : r_level;
    assign w_lvl     = (w_ay > w_base) ? w_ay : w_base;
    assign w_free    = !r_res_valid || !i_res_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_smp_valid) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_OUT;
            S_OUT:   if (w_free) n_state = r_fin ? S_EOF : S_IDLE;
            S_EOF:   if (!w_gstat.busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_acc        = (r_state == S_IDLE) && i_smp_valid;
        w_load       = (r_state == S_OUT) && w_free;
        o_smp_stall  = (r_state != S_IDLE);
        w_gctl.start = w_load && r_fin;
        w_gctl.agc   = r_agc;
        w_gctl.n     = LEN_X_W'(r_pos) + 1'b1;
        w_gctl.peak  = r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agc  <= 1'b1;
            r_flen <= LEN_RESET;
            r_vol  <= VOL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_AGC_ENABLE:   r_agc  <= i_cfg_wdata[0];
                CFG_FRAME_LENGTH: r_flen <= i_cfg_wdata[CFG_LEN_W-1:0];
                CFG_VOLUME:       r_vol  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_rd <= r_store[r_sp];
        if (r_state == S_MUL1) r_store[r_pos] <= r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_peak      <= '0;
            r_have      <= 1'b0;
            r_level     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_x   <= i_sample_in;
                r_pos <= r_sp;
                r_fin <= w_fin;
                r_sp  <= w_fin ? '0 : r_sp + 1'b1;
            end
            if (r_state == S_MUL1) begin
                r_mv    <= MV_W'(w_mag_in * r_vol);
                r_neg   <= r_rd[SMP_W-1];
                r_raw   <= r_rd;
                r_rprod <= RPROD_W'(r_pos * w_gstat.step);
                if ((r_pos == '0) || (w_ax > r_peak)) r_peak <= w_ax;
            end
            if (r_state == S_MUL2) begin
                r_g <= (w_gsum > (RPROD_W+1)'(RAMP_MAX)) ? RAMP_MAX : w_gsum[STEP_W-1:0];
            end
            if (r_state == S_MUL3) begin
                r_phi <= PP_W'(r_mv * r_g[31:16]);
                r_plo <= PP_W'(r_mv * r_g[15:0]);
            end
            if (w_load) begin
                r_res_valid  <= 1'b1;
                r_sample_out <= r_have ? w_y : '0;
                r_out_valid  <= r_have;
                r_out_last   <= r_have && r_fin;
                r_level_out  <= r_have ? w_lvl : '0;
                r_level      <= r_have ? w_lvl : w_base;
                if (r_fin) begin
                    r_have <= 1'b1;
                    r_peak <= '0;
                end
            end else if (o_res_valid && !i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    fpagc_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gctl),
        .o_stat  (w_gstat)
    );

    assign o_res_valid  = r_res_valid;
    assign o_sample_out = r_sample_out;
    assign o_out_valid  = r_out_valid;
    assign o_out_last   = r_out_last;
    assign o_level      = r_level_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_MUL1))
        else $error("accepted beat did not start the sample path");

    a_gain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_gstat.busy)
        else $error("gain update still running while taking samples");

    a_eof_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOF) |-> r_have)
        else $error("frame end reached without a stored frame");

endmodule
